// ----- rtl/point_camera_projection_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the point camera projection checker
// Use each macro on a line of its own in a module that has clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef POINT_CAMERA_PROJECTION_ASSERT_SVH
`define POINT_CAMERA_PROJECTION_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define PCP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("point_camera_projection: check failed");

// Implication with a fixed delay between the two sides.
`define PCP_ASSERT_DLY(lbl, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error("point_camera_projection: delayed check failed");

`endif

// ----- rtl/pcp_pkg.sv -----
// ----------------------------------------------------------------------------
// pcp_pkg
// Shared types and constants for the point camera projection pipeline.
// ----------------------------------------------------------------------------
package pcp_pkg;

    localparam int FRAC_BITS = 24;
    localparam int DIV_STEPS = FRAC_BITS + 1;
    localparam int RATIO_LAT = DIV_STEPS + 3;
    localparam int PIPE_LAT  = 5 + RATIO_LAT + 3;
    localparam int DLY_LEN   = RATIO_LAT + 3;
    localparam int NW        = 60;
    localparam int DW        = 44;
    localparam int TW        = 28;

    localparam logic signed [TW-1:0] T_ONE = TW'(1) << FRAC_BITS;
    localparam logic [20:0] DEPTH_MAX = 21'd2097151;
    localparam logic signed [26:0] SCR_MAX = 27'sd524287;
    localparam logic signed [26:0] SCR_MIN = -27'sd524288;

    localparam logic [2:0] REG_EYE     = 3'd0;
    localparam logic [2:0] REG_RIGHT   = 3'd1;
    localparam logic [2:0] REG_UP      = 3'd2;
    localparam logic [2:0] REG_FORWARD = 3'd3;
    localparam logic [2:0] REG_DEPTH   = 3'd4;
    localparam logic [2:0] REG_PROJ_X  = 3'd5;
    localparam logic [2:0] REG_PROJ_Y  = 3'd6;
    localparam logic [2:0] REG_CANVAS  = 3'd7;

    typedef struct packed {
        logic signed [19:0] point_x;
        logic signed [19:0] point_y;
        logic signed [19:0] point_z;
    } point_t;

    typedef struct packed {
        logic               visible;
        logic signed [19:0] screen_x;
        logic signed [19:0] screen_y;
        logic [20:0]        depth;
    } result_t;

    typedef struct packed {
        logic                 ok;
        logic signed [TW-1:0] t;
    } ratio_t;

endpackage

// ----- rtl/pcp_ratio.sv -----
// ----------------------------------------------------------------------------
// pcp_ratio
// Pipelined range check and restoring division of n by d, one quotient bit
// per stage, giving floor(n/d * 2^FRAC_BITS) and a pass flag.
// ----------------------------------------------------------------------------
module pcp_ratio (
    input  logic                                 clk,
    input  logic signed [pcp_pkg::NW-1:0]        n,
    input  logic signed [pcp_pkg::NW-1:0]        d,
    output pcp_pkg::ratio_t                      res
);

    localparam int NW = pcp_pkg::NW;
    localparam int DW = pcp_pkg::DW;
    localparam int TW = pcp_pkg::TW;
    localparam int DS = pcp_pkg::DIV_STEPS;

    logic signed [NW-1:0] n1_reg;
    logic signed [NW-1:0] d1_reg;
    logic                 dz1_reg;

    // make the divisor positive
    always_ff @(posedge clk)
    begin
        if (d < 0)
        begin
            n1_reg <= -n;
            d1_reg <= -d;
        end
        else
        begin
            n1_reg <= n;
            d1_reg <= d;
        end
        dz1_reg <= (d == '0);
    end

    logic signed [63:0] n4;
    logic signed [63:0] dn;
    logic signed [63:0] d5;
    logic               bad;
    logic signed [NW-1:0] n_abs;

    assign n4    = 64'(n1_reg) <<< 2;
    assign dn    = 64'(d1_reg);
    assign d5    = dn + (dn <<< 2);
    assign bad   = dz1_reg || (n4 < -dn) || (n4 > d5);
    assign n_abs = (n1_reg < 0) ? -n1_reg : n1_reg;

    logic [DW-1:0] a2_reg;
    logic [DW-1:0] dd2_reg;
    logic          neg2_reg;
    logic          ok2_reg;

    always_ff @(posedge clk)
    begin
        a2_reg   <= n_abs[DW-1:0];
        dd2_reg  <= d1_reg[DW-1:0];
        neg2_reg <= (n1_reg < 0);
        ok2_reg  <= !bad;
    end

    logic [DW-1:0] r_reg   [DS];
    logic [DW-1:0] dd_reg  [DS];
    logic [DS-1:0] q_reg   [DS];
    logic          neg_reg [DS];
    logic          ok_reg  [DS];

    // integer quotient bit
    always_ff @(posedge clk)
    begin
        if (a2_reg >= dd2_reg)
        begin
            r_reg[0] <= a2_reg - dd2_reg;
            q_reg[0] <= DS'(1);
        end
        else
        begin
            r_reg[0] <= a2_reg;
            q_reg[0] <= '0;
        end
        dd_reg[0]  <= dd2_reg;
        neg_reg[0] <= neg2_reg;
        ok_reg[0]  <= ok2_reg;
    end

    // fraction bits
    for (genvar k = 1; k < DS; k++)
    begin : g_step
        logic [DW:0] rs;
        logic [DW:0] rd;
        logic        ge;

        assign rs = {r_reg[k-1], 1'b0};
        assign rd = rs - {1'b0, dd_reg[k-1]};
        assign ge = (rs >= {1'b0, dd_reg[k-1]});

        always_ff @(posedge clk)
        begin
            r_reg[k]   <= ge ? rd[DW-1:0] : rs[DW-1:0];
            q_reg[k]   <= {q_reg[k-1][DS-2:0], ge};
            dd_reg[k]  <= dd_reg[k-1];
            neg_reg[k] <= neg_reg[k-1];
            ok_reg[k]  <= ok_reg[k-1];
        end
    end

    logic signed [TW-1:0] q_ext;
    logic signed [TW-1:0] q_neg;

    assign q_ext = TW'(q_reg[DS-1]);
    assign q_neg = -(q_ext + TW'(r_reg[DS-1] != '0));

    // round toward minus infinity for negative numerators
    always_ff @(posedge clk)
    begin
        res.t  <= neg_reg[DS-1] ? q_neg : q_ext;
        res.ok <= ok_reg[DS-1];
    end

endmodule

// ----- rtl/point_camera_projection.sv -----
// ----------------------------------------------------------------------------
// point_camera_projection
// Projects one world point per clock to screen pixels and camera depth.
// ----------------------------------------------------------------------------
// Takes one point per clock: busy stays low and start is taken every cycle.
// Each point gives one result word, with done high for exactly one cycle;
// the receiver cannot stall, so results must be taken as they come. The
// divider gives one quotient bit per stage for 25 bits, and the pipeline
// also holds range checks, the camera transform and the canvas placement.
// Configuration registers are written with cfg_we at any edge and must be
// stable while points are in flight. A rejected point gives visible low
// with all other fields zero.
// ----------------------------------------------------------------------------
module point_camera_projection (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pcp_pkg::point_t   point,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [63:0]       cfg_data,
    output logic              done,
    output pcp_pkg::result_t  result
);

    localparam int NW  = pcp_pkg::NW;
    localparam int TW  = pcp_pkg::TW;
    localparam int LAT = pcp_pkg::PIPE_LAT;
    localparam int DL  = pcp_pkg::DLY_LEN;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [59:0] eye_reg;
    logic [59:0] right_reg;
    logic [59:0] up_reg;
    logic [59:0] fwd_reg;
    logic [42:0] drm_reg;
    logic [63:0] projx_reg;
    logic [63:0] projy_reg;
    logic [63:0] canvas_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eye_reg    <= '0;
            right_reg  <= '0;
            up_reg     <= '0;
            fwd_reg    <= '0;
            drm_reg    <= '0;
            projx_reg  <= '0;
            projy_reg  <= '0;
            canvas_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pcp_pkg::REG_EYE:     eye_reg    <= cfg_data[59:0];
                pcp_pkg::REG_RIGHT:   right_reg  <= cfg_data[59:0];
                pcp_pkg::REG_UP:      up_reg     <= cfg_data[59:0];
                pcp_pkg::REG_FORWARD: fwd_reg    <= cfg_data[59:0];
                pcp_pkg::REG_DEPTH:   drm_reg    <= cfg_data[42:0];
                pcp_pkg::REG_PROJ_X:  projx_reg  <= cfg_data;
                pcp_pkg::REG_PROJ_Y:  projy_reg  <= cfg_data;
                pcp_pkg::REG_CANVAS:  canvas_reg <= cfg_data;
            endcase
        end
    end

    // Always ready: a new point can enter every cycle.
    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // ------------------------------------------------------------------
    // Valid chain, one bit per pipeline register stage
    // ------------------------------------------------------------------
    logic [LAT-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], accept};
    end

    assign done = vld_reg[LAT-1];

    // ------------------------------------------------------------------
    // Stage 1: offset from the eye
    // ------------------------------------------------------------------
    logic signed [19:0] pin  [3];
    logic signed [19:0] eyev [3];
    logic signed [20:0] d1_reg [3];

    assign pin[0] = point.point_x;
    assign pin[1] = point.point_y;
    assign pin[2] = point.point_z;

    for (genvar i = 0; i < 3; i++)
    begin : g_off
        assign eyev[i] = $signed(eye_reg[20*i +: 20]);

        always_ff @(posedge clk)
        begin
            d1_reg[i] <= 21'(pin[i]) - 21'(eyev[i]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: nine products of offset and axis components
    // ------------------------------------------------------------------
    logic [59:0]        axis_w [3];
    logic signed [40:0] prod_reg [3][3];

    assign axis_w[0] = right_reg;
    assign axis_w[1] = up_reg;
    assign axis_w[2] = fwd_reg;

    for (genvar j = 0; j < 3; j++)
    begin : g_axis
        for (genvar i = 0; i < 3; i++)
        begin : g_comp
            logic signed [19:0] ax;
            assign ax = $signed(axis_w[j][20*i +: 20]);

            always_ff @(posedge clk)
            begin
                prod_reg[j][i] <= d1_reg[i] * ax;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sum and floor to Q.10 camera coordinates
    // ------------------------------------------------------------------
    logic signed [24:0] cam_reg [3];

    for (genvar j = 0; j < 3; j++)
    begin : g_sum
        logic signed [42:0] sum;
        assign sum = 43'(prod_reg[j][0]) + 43'(prod_reg[j][1]) + 43'(prod_reg[j][2]);

        always_ff @(posedge clk)
        begin
            cam_reg[j] <= 25'(sum >>> 18);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: perspective scale products, depth and canvas checks
    // ------------------------------------------------------------------
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic [20:0]        nearv;
    logic [20:0]        farv;
    logic signed [25:0] zs;
    logic               depth_ok;
    logic               canvas_ok;
    logic [20:0]        zsat;

    assign sx    = $signed(projx_reg[31:0]);
    assign sy    = $signed(projy_reg[31:0]);
    // raise near to one LSB; far not above near means no far limit
    assign nearv = (drm_reg[20:0] == '0) ? 21'd1 : drm_reg[20:0];
    assign farv  = drm_reg[41:21];
    assign zs    = 26'(cam_reg[2]);

    assign depth_ok  = (zs >= $signed({5'b0, nearv}))
                    && !((farv > nearv) && (zs > $signed({5'b0, farv})));
    assign canvas_ok = (canvas_reg[47:32] > 16'd1) && (canvas_reg[63:48] > 16'd1);
    assign zsat      = (zs > $signed({5'b0, pcp_pkg::DEPTH_MAX})) ? pcp_pkg::DEPTH_MAX
                                                                  : cam_reg[2][20:0];

    logic signed [56:0] mx4_reg;
    logic signed [56:0] my4_reg;
    logic signed [24:0] x4_reg;
    logic signed [24:0] y4_reg;
    logic signed [24:0] z4_reg;
    logic               vis4_reg;
    logic [20:0]        zsat4_reg;

    always_ff @(posedge clk)
    begin
        mx4_reg   <= cam_reg[0] * sx;
        my4_reg   <= cam_reg[1] * sy;
        x4_reg    <= cam_reg[0];
        y4_reg    <= cam_reg[1];
        z4_reg    <= cam_reg[2];
        vis4_reg  <= depth_ok && canvas_ok;
        zsat4_reg <= zsat;
    end

    // ------------------------------------------------------------------
    // Stage 5: numerator and denominator of each normalized position
    // ------------------------------------------------------------------
    logic signed [31:0] lft;
    logic signed [31:0] rgt;
    logic signed [31:0] bot;
    logic signed [31:0] top;
    logic signed [NW-1:0] den;

    assign lft = $signed(projx_reg[31:0]);
    assign rgt = $signed(projx_reg[63:32]);
    assign bot = $signed(projy_reg[31:0]);
    assign top = $signed(projy_reg[63:32]);
    assign den = NW'(z4_reg) <<< 16;

    logic signed [NW-1:0] nx5_reg;
    logic signed [NW-1:0] dx5_reg;
    logic signed [NW-1:0] ny5_reg;
    logic signed [NW-1:0] dy5_reg;

    always_ff @(posedge clk)
    begin
        if (drm_reg[42])
        begin
            // orthographic: (x - left) / (right - left) in Q16.16
            nx5_reg <= (NW'(x4_reg) <<< 6) - NW'(lft);
            dx5_reg <= NW'(rgt) - NW'(lft);
            ny5_reg <= (NW'(y4_reg) <<< 6) - NW'(bot);
            dy5_reg <= NW'(top) - NW'(bot);
        end
        else
        begin
            // perspective: (x*sx + z) / (2z)
            nx5_reg <= NW'(mx4_reg) + den;
            dx5_reg <= den <<< 1;
            ny5_reg <= NW'(my4_reg) + den;
            dy5_reg <= den <<< 1;
        end
    end

    // Hold the depth result and early reject flag alongside the dividers.
    logic        vis_dly  [DL];
    logic [20:0] zsat_dly [DL];

    always_ff @(posedge clk)
    begin
        vis_dly[0]  <= vis4_reg;
        zsat_dly[0] <= zsat4_reg;
        for (int k = 1; k < DL; k++)
        begin
            vis_dly[k]  <= vis_dly[k-1];
            zsat_dly[k] <= zsat_dly[k-1];
        end
    end

    // Note: the stage-5 registers feed the dividers directly.
    logic vis5_unused;
    assign vis5_unused = 1'b0;

    // ------------------------------------------------------------------
    // Divider pipelines
    // ------------------------------------------------------------------
    pcp_pkg::ratio_t rx;
    pcp_pkg::ratio_t ry;

    pcp_ratio u_ratio_x (
        .clk (clk),
        .n   (nx5_reg),
        .d   (dx5_reg),
        .res (rx)
    );

    pcp_ratio u_ratio_y (
        .clk (clk),
        .n   (ny5_reg),
        .d   (dy5_reg),
        .res (ry)
    );

    // ------------------------------------------------------------------
    // Placement: flip y, scale by canvas size, add canvas position
    // ------------------------------------------------------------------
    logic signed [TW-1:0] tx1_reg;
    logic signed [TW-1:0] ty1_reg;
    logic                 ok1_reg;

    always_ff @(posedge clk)
    begin
        tx1_reg <= rx.t;
        ty1_reg <= pcp_pkg::T_ONE - ry.t;
        ok1_reg <= rx.ok && ry.ok && !vis5_unused;
    end

    logic signed [44:0] mulx2_reg;
    logic signed [44:0] muly2_reg;
    logic               ok2_reg;

    always_ff @(posedge clk)
    begin
        mulx2_reg <= tx1_reg * $signed({1'b0, canvas_reg[47:32]});
        muly2_reg <= ty1_reg * $signed({1'b0, canvas_reg[63:48]});
        ok2_reg   <= ok1_reg;
    end

    logic signed [26:0] vx;
    logic signed [26:0] vy;
    logic signed [19:0] sat_x;
    logic signed [19:0] sat_y;
    logic               vis_fin;

    assign vx = $signed({7'b0, canvas_reg[15:0], 4'b0}) + 27'(mulx2_reg >>> 20);
    assign vy = $signed({7'b0, canvas_reg[31:16], 4'b0}) + 27'(muly2_reg >>> 20);

    always_comb
    begin
        if (vx > pcp_pkg::SCR_MAX)
            sat_x = pcp_pkg::SCR_MAX[19:0];
        else if (vx < pcp_pkg::SCR_MIN)
            sat_x = pcp_pkg::SCR_MIN[19:0];
        else
            sat_x = vx[19:0];

        if (vy > pcp_pkg::SCR_MAX)
            sat_y = pcp_pkg::SCR_MAX[19:0];
        else if (vy < pcp_pkg::SCR_MIN)
            sat_y = pcp_pkg::SCR_MIN[19:0];
        else
            sat_y = vy[19:0];
    end

    assign vis_fin = vis_dly[DL-1] && ok2_reg;

    // Output register; drop everything but the flag on a rejected point.
    always_ff @(posedge clk)
    begin
        result.visible  <= vis_fin;
        result.screen_x <= vis_fin ? sat_x : '0;
        result.screen_y <= vis_fin ? sat_y : '0;
        result.depth    <= vis_fin ? zsat_dly[DL-1] : '0;
    end

endmodule

// ----- rtl/pcp_checker.sv -----
// ----------------------------------------------------------------------------
// pcp_checker
// Port-level checks of the point camera projection block, bound to the top.
// ----------------------------------------------------------------------------
`include "point_camera_projection_assert.svh"

module pcp_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input pcp_pkg::result_t  result
);

    `PCP_ASSERT_DLY(a_latency, start && !busy, pcp_pkg::PIPE_LAT, done)
    `PCP_ASSERT_IMP(a_no_stray, done, $past(start && !busy, pcp_pkg::PIPE_LAT))
    `PCP_ASSERT_IMP(a_reject_zero, done && !result.visible, (result.screen_x == 0) && (result.screen_y == 0) && (result.depth == 0))
    `PCP_ASSERT_IMP(a_depth_pos, done && result.visible, result.depth != 0)

endmodule

bind point_camera_projection pcp_checker u_pcp_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// ----- sim/point_camera_projection_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_camera_projection_tb
// Streams world points through the projection block under several camera
// settings and checks every result word against a cycle-free predictor.
// ----------------------------------------------------------------------------
module point_camera_projection_tb;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    pcp_pkg::point_t    point;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [63:0]        cfg_data;
    logic               done;
    pcp_pkg::result_t   result;

    point_camera_projection uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .point(point),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .result(result)
    );

    // Predictor copy of the register file.
    logic [59:0] eye_r, right_r, up_r, fwd_r;
    logic [42:0] range_r;
    logic [63:0] projx_r, projy_r, canvas_r;

    pcp_pkg::point_t  pending_points[$];
    pcp_pkg::result_t expected_words[$];
    int      errors;
    int      sender_idle_pct;
    bit      feeding;

    task automatic add_point(pcp_pkg::point_t p);
        pending_points.insert(pending_points.size(), p);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("point_camera_projection test failed");
        $finish;
    end

    function automatic longint fld_s(logic [63:0] v, int pos, int w);
        logic [63:0] f;
        f = (v >> pos) & ((64'd1 << w) - 1);
        if (f[w-1])
            return longint'(f) - (longint'(1) << w);
        return longint'(f);
    endfunction

    function automatic longint floor_div2(longint v, int s);
        return v >>> s;   // arithmetic shift floors toward minus infinity
    endfunction

    function automatic longint axis_dot(longint d0, longint d1, longint d2, logic [59:0] ax);
        longint acc;
        acc = d0 * fld_s(ax, 0, 20) + d1 * fld_s(ax, 20, 20) + d2 * fld_s(ax, 40, 20);
        return floor_div2(acc, 18);
    endfunction

    // Floored ratio n/d in FRAC_BITS fraction bits; false outside -1/4..5/4.
    function automatic bit unit_ratio(longint n, longint d, output longint t);
        longint q, r;
        t = 0;
        if (d == 0)
            return 0;
        if (d < 0)
        begin
            n = -n;
            d = -d;
        end
        if (4 * n < -d || 4 * n > 5 * d)
            return 0;
        q = n / d;
        r = n % d;
        if (r < 0)
        begin
            q = q - 1;
            r = r + d;
        end
        // r < d and d is small enough here that r << 24 fits in 64 bits
        for (int i = 0; i < pcp_pkg::FRAC_BITS; i++)
        begin
            q = q * 2;
            r = r * 2;
            if (r >= d)
            begin
                r = r - d;
                q = q + 1;
            end
        end
        t = q;
        return 1;
    endfunction

    function automatic logic [19:0] canvas_place(longint pos, longint size, longint t);
        longint v;
        v = pos * 16 + floor_div2(t * size * 16, pcp_pkg::FRAC_BITS);
        if (v > 524287)
            v = 524287;
        if (v < -524288)
            v = -524288;
        return v[19:0];
    endfunction

    function automatic pcp_pkg::result_t project_point(pcp_pkg::point_t p);
        pcp_pkg::result_t o;
        longint d0, d1, d2, x, y, z, nv, fv, tx, ty, l, r, b, t, den;
        longint px, py, w, h;
        bit ok;
        o = '0;
        px = canvas_r[15:0];
        py = canvas_r[31:16];
        w  = canvas_r[47:32];
        h  = canvas_r[63:48];
        if (w <= 1 || h <= 1)
            return o;
        d0 = longint'(p.point_x) - fld_s(eye_r, 0, 20);
        d1 = longint'(p.point_y) - fld_s(eye_r, 20, 20);
        d2 = longint'(p.point_z) - fld_s(eye_r, 40, 20);
        x = axis_dot(d0, d1, d2, right_r);
        y = axis_dot(d0, d1, d2, up_r);
        z = axis_dot(d0, d1, d2, fwd_r);
        nv = range_r[20:0];
        if (nv < 1)
            nv = 1;
        fv = range_r[41:21];
        if (z < nv)
            return o;
        if (fv > nv && z > fv)
            return o;
        if (range_r[42])
        begin
            l = fld_s(projx_r, 0, 32);
            r = fld_s(projx_r, 32, 32);
            b = fld_s(projy_r, 0, 32);
            t = fld_s(projy_r, 32, 32);
            ok = unit_ratio(x * 64 - l, r - l, tx);
            if (ok)
                ok = unit_ratio(y * 64 - b, t - b, ty);
        end
        else
        begin
            den = z * 65536;
            ok = unit_ratio(x * fld_s(projx_r, 0, 32) + den, 2 * den, tx);
            if (ok)
                ok = unit_ratio(y * fld_s(projy_r, 0, 32) + den, 2 * den, ty);
        end
        if (!ok)
            return o;
        o.visible  = 1'b1;
        o.screen_x = canvas_place(px, w, tx);
        o.screen_y = canvas_place(py, h, (longint'(1) << pcp_pkg::FRAC_BITS) - ty);
        o.depth    = (z > 2097151) ? 21'd2097151 : z[20:0];
        return o;
    endfunction

    // Driver: hold start while items remain; drop it on random idle cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            point <= '0;
        end
        else
        begin
            if (start && !busy)
                expected_words.insert(expected_words.size(), project_point(point));
            if ((!start || !busy) && pending_points.size() > 0 && feeding &&
                $urandom_range(99, 0) >= sender_idle_pct)
            begin
                start <= 1'b1;
                point <= pending_points.pop_front();
            end
            else if (!start || !busy)
                start <= 1'b0;
        end
    end

    // Monitor: every done word must match the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_words.size() == 0)
            begin
                $error("result word with nothing expected");
                errors++;
            end
            else
            begin
                pcp_pkg::result_t e;
                e = expected_words.pop_front();
                if (result.visible !== e.visible)
                begin
                    $error("visible: expected %0d got %0d", e.visible, result.visible);
                    errors++;
                end
                if (result.screen_x !== e.screen_x)
                begin
                    $error("screen_x: expected %0d got %0d", e.screen_x, result.screen_x);
                    errors++;
                end
                if (result.screen_y !== e.screen_y)
                begin
                    $error("screen_y: expected %0d got %0d", e.screen_y, result.screen_y);
                    errors++;
                end
                if (result.depth !== e.depth)
                begin
                    $error("depth: expected %0d got %0d", e.depth, result.depth);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            pcp_pkg::REG_EYE:     eye_r    = val[59:0];
            pcp_pkg::REG_RIGHT:   right_r  = val[59:0];
            pcp_pkg::REG_UP:      up_r     = val[59:0];
            pcp_pkg::REG_FORWARD: fwd_r    = val[59:0];
            pcp_pkg::REG_DEPTH:   range_r  = val[42:0];
            pcp_pkg::REG_PROJ_X:  projx_r  = val;
            pcp_pkg::REG_PROJ_Y:  projy_r  = val;
            default:              canvas_r = val;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until everything queued has been sent and checked, then drain.
    task automatic drain();
        while (pending_points.size() > 0 || start || expected_words.size() > 0)
            @(posedge clk);
        repeat (pcp_pkg::PIPE_LAT + 4) @(posedge clk);
    endtask

    function automatic logic [59:0] vec3(longint a, longint b, longint c);
        return {c[19:0], b[19:0], a[19:0]};
    endfunction

    function automatic logic [19:0] rnd20();
        return 20'($urandom());
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    // Mostly points around the eye so they land in the view; some raw noise.
    task automatic queue_scene(int n, longint spread);
        pcp_pkg::point_t p;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9, 0) < 8)
            begin
                p.point_x = 20'(fld_s(eye_r, 0, 20)
                    + $signed($urandom_range(32'(2 * spread), 0)) - spread);
                p.point_y = 20'(fld_s(eye_r, 20, 20)
                    + $signed($urandom_range(32'(2 * spread), 0)) - spread);
                p.point_z = 20'(fld_s(eye_r, 40, 20)
                    + $signed($urandom_range(32'(2 * spread), 0)) - spread);
            end
            else
            begin
                p.point_x = rnd20();
                p.point_y = rnd20();
                p.point_z = rnd20();
            end
            add_point(p);
        end
    endtask

    function automatic pcp_pkg::point_t mk_point(longint a, longint b, longint c);
        pcp_pkg::point_t p;
        p.point_x = a[19:0];
        p.point_y = b[19:0];
        p.point_z = c[19:0];
        return p;
    endfunction

    // Identity camera basis: right=x, up=y, forward=z (1.0 in Q2.18).
    task automatic identity_camera(longint ex, longint ey, longint ez);
        write_reg(pcp_pkg::REG_EYE, vec3(ex, ey, ez));
        write_reg(pcp_pkg::REG_RIGHT, vec3(262144, 0, 0));
        write_reg(pcp_pkg::REG_UP, vec3(0, 262144, 0));
        write_reg(pcp_pkg::REG_FORWARD, vec3(0, 0, 262144));
    endtask

    initial
    begin
        errors = 0;
        feeding = 1'b0;
        sender_idle_pct = 19;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        eye_r = '0; right_r = '0; up_r = '0; fwd_r = '0;
        range_r = '0; projx_r = '0; projy_r = '0; canvas_r = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers: every point, extremes included, is rejected.
        feeding = 1'b1;
        add_point(mk_point(-524288, -524288, -524288));
        add_point(mk_point(524287, 524287, 524287));
        add_point(mk_point(0, 0, 1024));
        drain();
        feeding = 1'b0;

        // Perspective, unit scales, near 1 (raised from 0), no far limit.
        identity_camera(0, 0, 0);
        write_reg(pcp_pkg::REG_DEPTH, {1'b0, 21'd0, 21'd0});
        write_reg(pcp_pkg::REG_PROJ_X, {32'hDEAD_BEEF, 32'h0001_0000});
        write_reg(pcp_pkg::REG_PROJ_Y, {32'hFFFF_FFFF, 32'h0001_0000});
        write_reg(pcp_pkg::REG_CANVAS, {16'd480, 16'd640, 16'd10, 16'd20});
        add_point(mk_point(0, 0, 1024));           // center
        add_point(mk_point(1536, 0, 1024));        // edge +1.5
        add_point(mk_point(1537, 0, 1024));        // just outside
        add_point(mk_point(-1536, -1536, 1024));
        add_point(mk_point(0, 0, 1));              // depth at near
        add_point(mk_point(0, 0, 0));              // depth below near
        add_point(mk_point(0, 0, -1024));          // behind camera
        add_point(mk_point(0, 0, 524287));         // large depth
        add_point(mk_point(-524288, 524287, 524287));
        feeding = 1'b1;
        drain();
        feeding = 1'b0;

        // Far limit, near limit, a far-off eye, canvas side of 1.
        write_reg(pcp_pkg::REG_DEPTH, {1'b0, 21'd4096, 21'd512});
        add_point(mk_point(0, 0, 4096));
        add_point(mk_point(0, 0, 4097));
        add_point(mk_point(0, 0, 511));
        feeding = 1'b1;
        drain();
        feeding = 1'b0;
        identity_camera(0, 0, -524288);
        write_reg(pcp_pkg::REG_DEPTH, {1'b0, 21'h1FFFFF, 21'h1FFFFF});
        add_point(mk_point(0, 0, 524287));          // below near and canvas height 1: rejected
        write_reg(pcp_pkg::REG_CANVAS, {16'd1, 16'd640, 16'd0, 16'd0});
        feeding = 1'b1;
        drain();
        feeding = 1'b0;
        // maximum canvas; the point lies below near and is rejected
        write_reg(pcp_pkg::REG_CANVAS, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        add_point(mk_point(0, 0, 524287));
        feeding = 1'b1;
        drain();
        feeding = 1'b0;

        // Orthographic: degenerate spans, then a box with an inverted y span.
        identity_camera(0, 0, 0);
        write_reg(pcp_pkg::REG_DEPTH, {1'b1, 21'd0, 21'd1});
        write_reg(pcp_pkg::REG_PROJ_X, {32'h0001_0000, 32'h0001_0000});
        write_reg(pcp_pkg::REG_PROJ_Y, {32'h0001_0000, 32'hFFFF_0000});
        write_reg(pcp_pkg::REG_CANVAS, {16'd480, 16'd640, 16'd0, 16'd0});
        add_point(mk_point(0, 0, 1024));
        feeding = 1'b1;
        drain();
        feeding = 1'b0;
        write_reg(pcp_pkg::REG_PROJ_X, {32'h0001_0000, 32'hFFFF_0000});
        write_reg(pcp_pkg::REG_PROJ_Y, {32'h0001_0000, 32'h0001_0000});
        add_point(mk_point(0, 0, 1024));
        feeding = 1'b1;
        drain();
        feeding = 1'b0;
        write_reg(pcp_pkg::REG_PROJ_Y, {32'hFFFF_0000, 32'h0001_0000});    // inverted span
        add_point(mk_point(512, 512, 1024));
        add_point(mk_point(-1536, 1536, 2048));
        add_point(mk_point(2048, 0, 2048));
        feeding = 1'b1;
        drain();
        feeding = 1'b0;

        // Random phases: random cameras and windows, three idle profiles.
        for (int ph = 0; ph < 24; ph++)
        begin
            longint s;
            sender_idle_pct = (ph < 8) ? 19 : (ph < 16) ? 81 : 0;
            if (ph % 4 == 3)
            begin
                write_reg(pcp_pkg::REG_EYE, rnd64());
                write_reg(pcp_pkg::REG_RIGHT, rnd64());
                write_reg(pcp_pkg::REG_UP, rnd64());
                write_reg(pcp_pkg::REG_FORWARD, rnd64());
                write_reg(pcp_pkg::REG_DEPTH, rnd64());
                write_reg(pcp_pkg::REG_PROJ_X, rnd64());
                write_reg(pcp_pkg::REG_PROJ_Y, rnd64());
                write_reg(pcp_pkg::REG_CANVAS, rnd64());
            end
            else
            begin
                identity_camera($signed(rnd20()) >>> 2, $signed(rnd20()) >>> 2,
                                $signed(rnd20()) >>> 2);
                if ($urandom_range(1, 0))
                begin
                    // Rotate with a small random skew to exercise all axis bits.
                    write_reg(pcp_pkg::REG_RIGHT, vec3(262144 - $urandom_range(4096, 0),
                        $signed($urandom_range(8192, 0)) - 4096, -$urandom_range(4096, 0)));
                    write_reg(pcp_pkg::REG_FORWARD, vec3($urandom_range(4096, 0),
                        -$urandom_range(4096, 0), 262144 - $urandom_range(4096, 0)));
                end
                if ($urandom_range(1, 0))
                begin
                    write_reg(pcp_pkg::REG_DEPTH, {1'b1, 21'($urandom_range(40000, 0)),
                                                   21'($urandom_range(100, 0))});
                    write_reg(pcp_pkg::REG_PROJ_X, {32'($urandom_range(65536 * 40, 65536)),
                                                    32'(-$urandom_range(65536 * 40, 0))});
                    write_reg(pcp_pkg::REG_PROJ_Y, {32'($urandom_range(65536 * 40, 65536)),
                                                    32'(-$urandom_range(65536 * 40, 0))});
                end
                else
                begin
                    write_reg(pcp_pkg::REG_DEPTH, {1'b0, 21'($urandom_range(60000, 0)),
                                                   21'($urandom_range(200, 0))});
                    write_reg(pcp_pkg::REG_PROJ_X,
                              {$urandom(), 32'($urandom_range(65536 * 4, 16384))});
                    write_reg(pcp_pkg::REG_PROJ_Y,
                              {$urandom(), 32'(-$urandom_range(65536 * 4, 16384))});
                end
                write_reg(pcp_pkg::REG_CANVAS,
                          {16'($urandom_range(1080, 0)), 16'($urandom_range(1920, 0)),
                           16'($urandom_range(500, 0)), 16'($urandom_range(500, 0))});
            end
            s = 1 << $urandom_range(15, 10);
            queue_scene(58, s);
            feeding = 1'b1;
            drain();
            feeding = 1'b0;
        end

        if (errors == 0)
            $display("point_camera_projection test passed");
        else
            $display("point_camera_projection test failed");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/pcp_pkg.sv
rtl/pcp_ratio.sv
rtl/point_camera_projection.sv
rtl/pcp_checker.sv
sim/point_camera_projection_tb.sv
